// ===== sv/tcw_pkg.sv =====
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned IndexW = 11;
  localparam int unsigned PosW   = 11;

  localparam logic [ByteW-1:0] NewlineCode = 8'h0A;
  localparam logic [ByteW-1:0] BlankCode   = 8'h20;
  localparam logic [ByteW-1:0] ResetColor  = 8'h0F;

  typedef enum logic [CmdW-1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } tcw_cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_COPY,
    S_BLANK,
    S_FILL
  } tcw_state_e;

  typedef struct packed {
    logic [ByteW-1:0] color;
    logic [ByteW-1:0] char_code;
  } tcw_cell_t;

  typedef struct packed {
    logic [CmdW-1:0]   cmd;
    logic [ByteW-1:0]  char_code;
    logic [IndexW-1:0] cell_index;
  } tcw_req_t;

  typedef struct packed {
    logic [PosW-1:0]  cursor_pos;
    logic [ByteW-1:0] read_char;
    logic [ByteW-1:0] read_color;
  } tcw_rsp_t;

endpackage

// ===== sv/tcw_screen_ram.sv =====
`timescale 1ns / 1ps

module tcw_screen_ram
  import tcw_pkg::*;
#(
  parameter int unsigned DEPTH  = 2000,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  tcw_cell_t         wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output tcw_cell_t         rdata_o
);

  tcw_cell_t mem [DEPTH];
  tcw_cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/text_console_writer_top.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                        Payload
// command   in         start & !busy                    req_i   (cmd, char_code, cell_index)
// result    out        done_o, one cycle, no stall      rsp_o   (cursor_pos, read_char, read_color)
// config    in         cfg_we_i, taken every edge       cfg_wdata_i (text_color)
//
// A put without scroll, an unused command and an out-of-range read give their result in the
// next cycle; an in-range read passes the registered memory read and the S_READ state first.
// A put that scrolls moves rows up in S_COPY and blanks the bottom row in S_BLANK, and a clear
// blanks every cell in S_FILL; one cell is moved or blanked per cycle through the single write port.
// After reset a clearing pass blanks all ROWS*COLUMNS cells of the memory with busy held high.
// The result strobe cannot be stalled; a new command may be taken while a result is shown.

module text_console_writer_top
  import tcw_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  tcw_req_t         req_i,
  output logic             done_o,
  output tcw_rsp_t         rsp_o,
  input  logic             cfg_we_i,
  input  logic [ByteW-1:0] cfg_wdata_i
);

  localparam int unsigned CellCount = COLUMNS * ROWS;
  localparam int unsigned MoveCount = CellCount - COLUMNS;
  localparam int unsigned AddrW     = $clog2(CellCount);
  localparam int unsigned RowW      = $clog2(ROWS);
  localparam int unsigned ColW      = $clog2(COLUMNS);

  tcw_state_e       state_q, state_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [AddrW-1:0] cnt_q, cnt_d;
  logic [ByteW-1:0] fill_color_q, fill_color_d;
  logic             report_q, report_d;
  logic [ByteW-1:0] text_color_q, text_color_d;
  logic             done_q, done_d;
  tcw_rsp_t         rsp_q, rsp_d;

  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  tcw_cell_t        ram_wdata, ram_rdata;

  logic [AddrW-1:0] cur_addr;
  logic [AddrW-1:0] pos_next;
  logic [ByteW-1:0] rd_char, rd_color;

  tcw_screen_ram #(
    .DEPTH (CellCount),
    .ADDR_W(AddrW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign cur_addr = AddrW'(row_q) * AddrW'(COLUMNS) + AddrW'(col_q);
  assign pos_next = AddrW'(row_d) * AddrW'(COLUMNS) + AddrW'(col_d);
  assign text_color_d = cfg_we_i ? cfg_wdata_i : text_color_q;

  always_comb begin
    state_d      = state_q;
    row_d        = row_q;
    col_d        = col_q;
    cnt_d        = cnt_q;
    fill_color_d = fill_color_q;
    report_d     = report_q;
    done_d       = 1'b0;
    rd_char      = '0;
    rd_color     = '0;
    ram_we       = 1'b0;
    ram_waddr    = cnt_q;
    ram_wdata    = '{color: text_color_q, char_code: BlankCode};
    ram_re       = 1'b0;
    ram_raddr    = cnt_q + AddrW'(COLUMNS);

    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (req_i.cmd)
            CMD_PUT: begin
              if (req_i.char_code != NewlineCode) begin
                ram_we    = 1'b1;
                ram_waddr = cur_addr;
                ram_wdata = '{color: text_color_q, char_code: req_i.char_code};
              end
              if (req_i.char_code == NewlineCode || col_q == ColW'(COLUMNS - 1)) begin
                col_d = '0;
                if (row_q == RowW'(ROWS - 1)) begin
                  // Bottom row overflows: move everything up one row first.
                  cnt_d   = '0;
                  state_d = S_COPY;
                end else begin
                  row_d  = row_q + RowW'(1);
                  done_d = 1'b1;
                end
              end else begin
                col_d  = col_q + ColW'(1);
                done_d = 1'b1;
              end
            end
            CMD_CLEAR: begin
              row_d        = '0;
              col_d        = '0;
              cnt_d        = '0;
              fill_color_d = text_color_q;
              report_d     = 1'b1;
              state_d      = S_FILL;
            end
            CMD_READ: begin
              if (32'(req_i.cell_index) < 32'(CellCount)) begin
                ram_re    = 1'b1;
                ram_raddr = AddrW'(req_i.cell_index);
                state_d   = S_READ;
              end else begin
                done_d = 1'b1;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        rd_char  = ram_rdata.char_code;
        rd_color = ram_rdata.color;
        done_d   = 1'b1;
        state_d  = S_IDLE;
      end
      S_COPY: begin
        // The read runs one row ahead; each cycle but the first writes back the cell read in the last one.
        if (cnt_q != '0) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_q - AddrW'(1);
          ram_wdata = ram_rdata;
        end
        if (cnt_q == AddrW'(MoveCount)) begin
          state_d = S_BLANK;
        end else begin
          ram_re = 1'b1;
          cnt_d  = cnt_q + AddrW'(1);
        end
      end
      S_BLANK: begin
        ram_we = 1'b1;
        if (cnt_q == AddrW'(CellCount - 1)) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + AddrW'(1);
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = '{color: fill_color_q, char_code: BlankCode};
        if (cnt_q == AddrW'(CellCount - 1)) begin
          // The pass after reset reports nothing; a clear command reports once.
          done_d   = report_q;
          report_d = 1'b0;
          state_d  = S_IDLE;
        end else begin
          cnt_d = cnt_q + AddrW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    rsp_d.cursor_pos = PosW'(pos_next);
    rsp_d.read_char  = rd_char;
    rsp_d.read_color = rd_color;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_FILL;
      row_q        <= '0;
      col_q        <= '0;
      cnt_q        <= '0;
      fill_color_q <= ResetColor;
      report_q     <= 1'b0;
      text_color_q <= ResetColor;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      row_q        <= row_d;
      col_q        <= col_d;
      cnt_q        <= cnt_d;
      fill_color_q <= fill_color_d;
      report_q     <= report_d;
      text_color_q <= text_color_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_d) begin
      rsp_q <= rsp_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import tcw_pkg::*;

  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;
  localparam int unsigned CELLS   = COLUMNS * ROWS;
  localparam int unsigned IndexMax = (1 << IndexW) - 1;
  localparam int unsigned RandomItems = 2000;

  // The command field has one encoding that the block does not use.
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  logic             busy;
  tcw_req_t         req_i       = '0;
  logic             done_o;
  tcw_rsp_t         rsp_o;
  logic             cfg_we_i    = 1'b0;
  logic [ByteW-1:0] cfg_wdata_i = '0;

  text_console_writer_top #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the console: screen contents, cursor and pen color.
  tcw_cell_t        screen [CELLS];
  int unsigned      cur_row;
  int unsigned      cur_col;
  logic [ByteW-1:0] pen_color;

  tcw_rsp_t    awaited_reports [$];
  int unsigned n_cmds     = 0;
  int unsigned n_checked  = 0;
  int unsigned n_scrolls  = 0;
  int unsigned n_clears   = 0;
  int unsigned fail_count = 0;
  int unsigned gap_pct    = 0;

  function automatic void blank_screen();
    int unsigned i;
    for (i = 0; i < CELLS; i++) screen[i] = '{color: pen_color, char_code: BlankCode};
    cur_row = 0;
    cur_col = 0;
  endfunction

  function automatic tcw_rsp_t console_apply(tcw_req_t r);
    tcw_rsp_t    rsp;
    int unsigned i;
    rsp = '0;
    case (r.cmd)
      CMD_PUT: begin
        if (r.char_code == NewlineCode) begin
          cur_col = 0;
          cur_row++;
        end else begin
          screen[cur_row * COLUMNS + cur_col] = '{color: pen_color, char_code: r.char_code};
          cur_col++;
        end
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        // Running off the bottom shifts everything up a row and opens a blank line.
        if (cur_row >= ROWS) begin
          for (i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
          for (i = CELLS - COLUMNS; i < CELLS; i++)
            screen[i] = '{color: pen_color, char_code: BlankCode};
          cur_row = ROWS - 1;
          n_scrolls++;
        end
      end
      CMD_CLEAR: begin
        blank_screen();
        n_clears++;
      end
      CMD_READ: begin
        if (r.cell_index < CELLS) begin
          rsp.read_char  = screen[r.cell_index].char_code;
          rsp.read_color = screen[r.cell_index].color;
        end
      end
      default: ;
    endcase
    rsp.cursor_pos = PosW'(cur_row * COLUMNS + cur_col);
    return rsp;
  endfunction

  typedef struct {
    bit               to_cfg;
    logic [ByteW-1:0] color;
    tcw_req_t         req;
    int unsigned      reps;
    bit               typed;
    tcw_rsp_t         rsp;
  } plan_row_t;

  plan_row_t plan [$];

  function automatic void plan_cmd(logic [CmdW-1:0] cmd, logic [ByteW-1:0] ch,
                                   logic [IndexW-1:0] idx, int unsigned reps, bit typed,
                                   logic [PosW-1:0] pos = '0, logic [ByteW-1:0] rch = '0,
                                   logic [ByteW-1:0] rcol = '0);
    plan_row_t row;
    row.to_cfg         = 1'b0;
    row.color          = '0;
    row.req.cmd        = cmd;
    row.req.char_code  = ch;
    row.req.cell_index = idx;
    row.reps           = reps;
    row.typed          = typed;
    row.rsp.cursor_pos = pos;
    row.rsp.read_char  = rch;
    row.rsp.read_color = rcol;
    plan.push_back(row);
  endfunction

  function automatic void plan_cfg(logic [ByteW-1:0] color);
    plan_row_t row;
    row        = '{default: '0};
    row.to_cfg = 1'b1;
    row.color  = color;
    plan.push_back(row);
  endfunction

  function automatic tcw_req_t random_cmd(int unsigned nl_odds);
    tcw_req_t    r;
    int unsigned sel;
    int unsigned here;
    int unsigned back;
    r.cmd        = CMD_PUT;
    r.char_code  = 8'($urandom_range(255));
    r.cell_index = IndexW'($urandom_range(IndexMax));
    sel = $urandom_range(999);
    if (sel < 620) begin
      if ($urandom_range(nl_odds - 1) == 0) r.char_code = NewlineCode;
    end else if (sel < 950) begin
      r.cmd = CMD_READ;
      sel = $urandom_range(9);
      here = cur_row * COLUMNS + cur_col;
      // Reads just behind the cursor mostly land on freshly written text.
      if (sel < 5) begin
        back = $urandom_range(2 * COLUMNS);
        r.cell_index = IndexW'(here >= back ? here - back : here);
      end else if (sel < 9) begin
        r.cell_index = IndexW'($urandom_range(CELLS - 1));
      end else begin
        r.cell_index = IndexW'($urandom_range(IndexMax, CELLS));
      end
    end else if (sel < 997) begin
      r.cmd = CmdUnused;
    end else begin
      r.cmd = CMD_CLEAR;
    end
    return r;
  endfunction

  task automatic issue(tcw_req_t r, bit typed, tcw_rsp_t want);
    tcw_rsp_t pred;
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    pred = console_apply(r);
    awaited_reports.push_back(typed ? want : pred);
    n_cmds++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (awaited_reports.size() != 0 || busy !== 1'b0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_pen(logic [ByteW-1:0] color);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= color;
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    pen_color = color;
  endtask

  always @(posedge clk_i) begin
    tcw_rsp_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (awaited_reports.size() == 0) begin
        $error("result with no command outstanding: cursor_pos %0d", rsp_o.cursor_pos);
        fail_count++;
      end else begin
        want = awaited_reports.pop_front();
        n_checked++;
        if (rsp_o.cursor_pos !== want.cursor_pos) begin
          $error("cursor_pos: expected %0d, got %0d", want.cursor_pos, rsp_o.cursor_pos);
          fail_count++;
        end
        if (rsp_o.read_char !== want.read_char) begin
          $error("read_char: expected %h, got %h", want.read_char, rsp_o.read_char);
          fail_count++;
        end
        if (rsp_o.read_color !== want.read_color) begin
          $error("read_color: expected %h, got %h", want.read_color, rsp_o.read_color);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #100_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int unsigned gap_by_phase [3];
    int unsigned nl_by_phase [3];
    int unsigned p;
    gap_by_phase = '{20, 50, 0};
    nl_by_phase  = '{10, 40, 5};
    pen_color = ResetColor;
    blank_screen();

    // Reset state, out-of-range reads, the unused command, puts and reads under pen changes, a clear.
    plan_cmd(CMD_READ, 8'h00, 11'd0, 1, 1'b1, 11'd0, BlankCode, ResetColor);
    plan_cmd(CMD_READ, 8'hFF, IndexW'(CELLS - 1), 1, 1'b1, 11'd0, BlankCode, ResetColor);
    plan_cmd(CMD_READ, 8'h00, IndexW'(CELLS), 1, 1'b1);
    plan_cmd(CMD_READ, 8'h55, IndexW'(IndexMax), 1, 1'b1);
    plan_cmd(CmdUnused, 8'hFF, IndexW'(IndexMax), 1, 1'b1);
    plan_cmd(CMD_PUT, 8'h41, 11'd0, 1, 1'b1, 11'd1);
    plan_cmd(CMD_PUT, 8'h00, IndexW'(IndexMax), 1, 1'b0);
    plan_cmd(CMD_PUT, 8'hFF, 11'd0, 1, 1'b0);
    plan_cmd(CMD_READ, 8'h00, 11'd0, 1, 1'b1, 11'd3, 8'h41, ResetColor);
    plan_cmd(CMD_READ, 8'h00, 11'd2, 1, 1'b1, 11'd3, 8'hFF, ResetColor);
    plan_cfg(8'h00);
    plan_cmd(CMD_PUT, NewlineCode, 11'd0, 1, 1'b1, PosW'(COLUMNS));
    plan_cmd(CMD_PUT, BlankCode, 11'd0, 1, 1'b0);
    plan_cmd(CMD_READ, 8'h00, IndexW'(COLUMNS), 1, 1'b1, PosW'(COLUMNS + 1), BlankCode,
             8'h00);
    plan_cfg(8'hFF);
    plan_cmd(CMD_CLEAR, 8'hAA, 11'h555, 1, 1'b1);
    plan_cmd(CMD_READ, 8'h00, IndexW'(CELLS - 1), 1, 1'b1, 11'd0, BlankCode, 8'hFF);
    // Fill the top line to force a wrap, then walk down and scroll twice.
    plan_cmd(CMD_PUT, 8'h5A, 11'd0, COLUMNS - 1, 1'b0);
    plan_cmd(CMD_PUT, 8'h7E, 11'd0, 1, 1'b1, PosW'(COLUMNS));
    plan_cmd(CMD_PUT, NewlineCode, 11'd0, ROWS - 2, 1'b0);
    plan_cmd(CMD_READ, 8'h00, 11'd0, 1, 1'b1, PosW'((ROWS - 1) * COLUMNS), 8'h5A, 8'hFF);
    plan_cmd(CMD_PUT, 8'h71, 11'd0, COLUMNS, 1'b0);
    plan_cmd(CMD_PUT, NewlineCode, 11'd0, 1, 1'b1, PosW'((ROWS - 1) * COLUMNS));
    plan_cmd(CMD_READ, 8'h00, IndexW'((ROWS - 3) * COLUMNS + 5), 1, 1'b0);
    plan_cmd(CMD_READ, 8'h00, IndexW'((ROWS - 1) * COLUMNS), 1, 1'b1,
             PosW'((ROWS - 1) * COLUMNS), BlankCode, 8'hFF);

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    // The block blanks its memory after reset before taking commands.
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);

    gap_pct = gap_by_phase[0];
    foreach (plan[k]) begin
      if (plan[k].to_cfg) begin
        set_pen(plan[k].color);
      end else begin
        repeat (plan[k].reps) issue(plan[k].req, plan[k].typed, plan[k].rsp);
      end
    end

    for (p = 0; p < 3; p++) begin
      set_pen(8'($urandom_range(255)));
      gap_pct = gap_by_phase[p];
      repeat (RandomItems / 3) issue(random_cmd(nl_by_phase[p]), 1'b0, '0);
    end

    settle();
    repeat (8) @(posedge clk_i);
    $display("Checked %0d results for %0d commands under several pen colors.", n_checked,
             n_cmds);
    $display("The run went through %0d scrolls and %0d clears.", n_scrolls, n_clears);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
